>>> hdl/rrq_pkg.sv
`default_nettype none

package rrq_pkg;

   localparam int ID_W = 4;
   localparam int OP_W = 2;

   typedef logic [ID_W-1:0] thread_id_type;
   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_INSERT   = 2'd0;
   localparam op_type OP_DESTROY  = 2'd1;
   localparam op_type OP_BLOCK    = 2'd2;
   localparam op_type OP_ACTIVATE = 2'd3;

endpackage

`default_nettype wire

>>> hdl/rrq_link_ram.sv
`default_nettype none

module rrq_link_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [AW-1:0]         wr_addr,
   input  wire rrq_pkg::thread_id_type wr_data,
   input  wire logic [AW-1:0]         rd_addr,
   output      rrq_pkg::thread_id_type rd_data
);
   import rrq_pkg::*;

   thread_id_type mem [DEPTH];
   thread_id_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/round_robin_run_queue.sv
`default_nettype none

// FIFO run queue of thread ids with a current thread. The queue order is kept
// as a table of next pointers in a single-port-read, single-port-write
// memory; head, tail, count and the current thread sit in registers. One
// transaction is worked at a time. An insert first clears the link of the new
// tail, then points the old tail at it; an insert that is dropped (full queue
// or id out of range) writes nothing. Block and activate fetch the new head
// from the link memory when the queue keeps entries after the pop, and
// destroy of a queued thread walks the queue from the head, one link per cycle
// through the memory read port; an absent thread is dropped once the walk
// reaches the tail. The input side is taken again while a finished result
// still waits in the output register. The link memory needs no clearing after
// reset: an entry is only read after it has been written.
module round_robin_run_queue #(
   parameter int MAX_THREADS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire rrq_pkg::op_type        req_op,
   input  wire rrq_pkg::thread_id_type req_thread_id,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      rrq_pkg::thread_id_type rsp_current_thread,
   output      logic                   rsp_current_valid,
   output      logic                   rsp_runnable,
   output      logic                   rsp_became_runnable,
   output      logic                   rsp_no_runnable_error
);
   import rrq_pkg::*;

   localparam int AW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int CW = $clog2(MAX_THREADS + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_POP  = 3'd1;
   localparam logic [2:0] S_WALK = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_LINK = 3'd4;

   logic [2:0]    state_ff, state_in;
   thread_id_type head_ff, head_in;
   thread_id_type tail_ff, tail_in;
   thread_id_type cur_ff, cur_in;
   logic          cur_valid_ff, cur_valid_in;
   logic [CW-1:0] count_ff, count_in;
   thread_id_type tid_ff, tid_in;
   thread_id_type walk_ff, walk_in;
   thread_id_type prev_ff, prev_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          became_ff, became_in;
   logic          err_ff, err_in;

   logic          rsp_valid_ff, rsp_valid_in;
   thread_id_type rsp_cur_ff, rsp_cur_in;
   logic          rsp_cv_ff, rsp_cv_in;
   logic          rsp_run_ff, rsp_run_in;
   logic          rsp_bec_ff, rsp_bec_in;
   logic          rsp_err_ff, rsp_err_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   thread_id_type wr_data;
   logic [AW-1:0] rd_addr;
   thread_id_type rd_data;

   logic          accept;
   logic          id_ok;
   logic          room_ok;
   logic          do_pop;
   logic          last_idx;

   rrq_link_ram #(
      .DEPTH (MAX_THREADS),
      .AW    (AW)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign id_ok     = 32'(req_thread_id) < MAX_THREADS;
   assign room_ok   = 32'(count_ff) < MAX_THREADS;
   assign last_idx  = (idx_ff + CW'(1)) == count_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      count_in     = count_ff;
      tid_in       = tid_ff;
      walk_in      = walk_ff;
      prev_in      = prev_ff;
      idx_in       = idx_ff;
      became_in    = became_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cur_in   = rsp_cur_ff;
      rsp_cv_in    = rsp_cv_ff;
      rsp_run_in   = rsp_run_ff;
      rsp_bec_in   = rsp_bec_ff;
      rsp_err_in   = rsp_err_ff;
      wr_en        = 1'b0;
      wr_addr      = AW'(tail_ff);
      wr_data      = req_thread_id;
      rd_addr      = AW'(head_ff);
      do_pop       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               tid_in    = req_thread_id;
               became_in = 1'b0;
               err_in    = 1'b0;
               state_in  = S_FIN;
               unique case (req_op)
                  OP_INSERT: begin
                     if (id_ok && room_ok) begin
                        became_in = (count_ff == '0);
                        if (count_ff == '0) begin
                           head_in = req_thread_id;
                        end
                        // clear the new tail's link, append it next cycle
                        wr_en    = 1'b1;
                        wr_addr  = AW'(req_thread_id);
                        wr_data  = '0;
                        prev_in  = tail_ff;
                        tail_in  = req_thread_id;
                        count_in = count_ff + CW'(1);
                        state_in = S_LINK;
                     end
                  end
                  OP_DESTROY: begin
                     if (cur_valid_ff && cur_ff == req_thread_id) begin
                        do_pop = 1'b1;
                     end else if (id_ok && count_ff != '0) begin
                        // the head link is being fetched this cycle
                        walk_in  = head_ff;
                        prev_in  = '0;
                        idx_in   = '0;
                        state_in = S_WALK;
                     end
                  end
                  OP_BLOCK: begin
                     do_pop = 1'b1;
                  end
                  OP_ACTIVATE: begin
                     if (!cur_valid_ff) begin
                        do_pop = 1'b1;
                        err_in = (count_ff == '0);
                     end
                  end
               endcase

               if (do_pop) begin
                  if (count_ff == '0) begin
                     cur_valid_in = 1'b0;
                     cur_in       = '0;
                  end else begin
                     cur_in       = head_ff;
                     cur_valid_in = 1'b1;
                     count_in     = count_ff - CW'(1);
                     if (count_ff == CW'(1)) begin
                        head_in = '0;
                        tail_in = '0;
                     end else begin
                        state_in = S_POP;
                     end
                  end
               end
            end
         end
         S_LINK: begin
            // point the old tail at the new one
            if (!became_ff) begin
               wr_en   = 1'b1;
               wr_addr = AW'(prev_ff);
               wr_data = tid_ff;
            end
            state_in = S_FIN;
         end
         S_POP: begin
            head_in  = rd_data;
            state_in = S_FIN;
         end
         S_WALK: begin
            // rd_data holds the link of walk_ff
            rd_addr = AW'(rd_data);
            if (walk_ff == tid_ff) begin
               if (idx_ff == '0) begin
                  head_in = rd_data;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = AW'(prev_ff);
                  wr_data = rd_data;
               end
               if (last_idx) begin
                  tail_in = prev_ff;
               end
               count_in = count_ff - CW'(1);
               if (count_ff == CW'(1)) begin
                  head_in = '0;
                  tail_in = '0;
               end
               state_in = S_FIN;
            end else if (last_idx) begin
               // absent thread: drop the walk
               state_in = S_FIN;
            end else begin
               prev_in = walk_ff;
               walk_in = rd_data;
               idx_in  = idx_ff + CW'(1);
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_cur_in   = cur_valid_ff ? cur_ff : '0;
               rsp_cv_in    = cur_valid_ff;
               rsp_run_in   = cur_valid_ff || (count_ff != '0);
               rsp_bec_in   = became_ff;
               rsp_err_in   = err_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         cur_ff       <= '0;
         cur_valid_ff <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cur_ff       <= cur_in;
         cur_valid_ff <= cur_valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tid_ff     <= tid_in;
      walk_ff    <= walk_in;
      prev_ff    <= prev_in;
      idx_ff     <= idx_in;
      became_ff  <= became_in;
      err_ff     <= err_in;
      rsp_cur_ff <= rsp_cur_in;
      rsp_cv_ff  <= rsp_cv_in;
      rsp_run_ff <= rsp_run_in;
      rsp_bec_ff <= rsp_bec_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_current_thread    = rsp_cur_ff;
   assign rsp_current_valid     = rsp_cv_ff;
   assign rsp_runnable          = rsp_run_ff;
   assign rsp_became_runnable   = rsp_bec_ff;
   assign rsp_no_runnable_error = rsp_err_ff;

endmodule

`default_nettype wire

>>> hdl/rrq_checker.sv
`default_nettype none

module rrq_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire rrq_pkg::op_type        req_op,
   input wire rrq_pkg::thread_id_type req_thread_id,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire rrq_pkg::thread_id_type rsp_current_thread,
   input wire logic                   rsp_current_valid,
   input wire logic                   rsp_runnable,
   input wire logic                   rsp_became_runnable,
   input wire logic                   rsp_no_runnable_error
);
   import rrq_pkg::*;

   // hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_current_thread)
         && $stable(rsp_current_valid) && $stable(rsp_runnable)
         && $stable(rsp_became_runnable) && $stable(rsp_no_runnable_error))
      else $error("result changed while stalled");

   // the sequencer does not take a request in the cycle after it accepts one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken on consecutive cycles");

   a_current_runnable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_current_valid || rsp_became_runnable) |-> rsp_runnable)
      else $error("current or new thread without runnable");

   a_error_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_runnable_error |->
         !rsp_current_valid && !rsp_runnable && !rsp_became_runnable)
      else $error("no-runnable error with runnable state");

   a_idle_thread_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_current_valid |-> rsp_current_thread == '0)
      else $error("current thread reported without current valid");

endmodule

bind round_robin_run_queue rrq_checker u_rrq_checker (.*);

`default_nettype wire
